// File: rtl/core/shape_fill_pixel_coverage_assert.svh
// Assertion macros used by the checker of the shape fill pixel coverage block.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef SHAPE_FILL_PIXEL_COVERAGE_ASSERT_SVH
`define SHAPE_FILL_PIXEL_COVERAGE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFPC_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
	else $error("shape fill pixel coverage check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFPC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
	else $error("shape fill pixel coverage check failed");

`endif

// File: rtl/core/sfpc_pkg.sv
// Package for the shape fill pixel coverage block: screen size, widths, codes,
// configuration and pipeline stage types. Depends on nothing.
package sfpc_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 128;

	localparam int COORD_W    = 7;
	localparam int ADDR_W     = 14;
	localparam int COLOR_W    = 16;
	localparam int GEOM_W     = 11;
	localparam int OFS_W      = GEOM_W + 1;
	localparam int MAG_W      = GEOM_W - 1;
	localparam int MAG2_W     = 2 * MAG_W;
	localparam int PROD_W     = 2 * MAG2_W;
	localparam int RAD_W      = GEOM_W - 2;
	localparam int RAD2_W     = 2 * RAD_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		MODE_CLEAR   = 2'd0,
		MODE_RECT    = 2'd1,
		MODE_ELLIPSE = 2'd2,
		MODE_ROUNDED = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHAPE_MODE    = 3'd0,
		REG_ORIGIN_X      = 3'd1,
		REG_ORIGIN_Y      = 3'd2,
		REG_EXTENT_W      = 3'd3,
		REG_EXTENT_H      = 3'd4,
		REG_CORNER_RADIUS = 3'd5,
		REG_FILL_COLOR    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		mode_t              mode;
		logic [GEOM_W-1:0]  ox;
		logic [GEOM_W-1:0]  oy;
		logic [GEOM_W-1:0]  w;
		logic [GEOM_W-1:0]  h;
		logic [GEOM_W-1:0]  cr;
		logic [COLOR_W-1:0] color;
	} cfg_t;

	typedef struct packed {
		logic               onscreen;
		mode_t              mode;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] word;
		logic               in_rect;
		logic               ell_ok;
		logic [MAG_W-1:0]   ai;
		logic [MAG_W-1:0]   aj;
		logic [OFS_W-1:0]   i;
		logic [OFS_W-1:0]   j;
		logic [RAD_W-1:0]   reff;
	} s1_t;

	typedef struct packed {
		logic               onscreen;
		mode_t              mode;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] word;
		logic               in_rect;
		logic               ell_ok;
		logic [MAG2_W-1:0]  ai2;
		logic [MAG2_W-1:0]  aj2;
		logic [MAG2_W-1:0]  rx2;
		logic [MAG2_W-1:0]  ry2;
		logic               corner;
		logic [RAD_W-1:0]   dx;
		logic [RAD_W-1:0]   dy;
		logic [RAD_W-1:0]   reff;
	} s2_t;

	typedef struct packed {
		logic               onscreen;
		mode_t              mode;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] word;
		logic               in_rect;
		logic               ell_ok;
		logic [PROD_W-1:0]  ell_a;
		logic [PROD_W-1:0]  ell_b;
		logic [PROD_W-1:0]  ell_r;
		logic               corner;
		logic [RAD2_W-1:0]  dx2;
		logic [RAD2_W-1:0]  dy2;
		logic [RAD2_W-1:0]  r2;
	} s3_t;

	function automatic logic [OFS_W-1:0] sext_ofs(input logic [GEOM_W-1:0] v);
		return {{(OFS_W-GEOM_W){v[GEOM_W-1]}}, v};
	endfunction

endpackage

// File: rtl/core/sfpc_cfg_regs.sv
// Configuration register file of the shape fill pixel coverage block.
// Depends on sfpc_pkg for the register codes and the configuration type.
module sfpc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfpc_pkg::CFG_DATA_W-1:0] cfg_data,
	output sfpc_pkg::cfg_t                  cfg
);
	import sfpc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= MODE_CLEAR;
			cfg_q.ox    <= '0;
			cfg_q.oy    <= '0;
			cfg_q.w     <= '0;
			cfg_q.h     <= '0;
			cfg_q.cr    <= '0;
			cfg_q.color <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SHAPE_MODE:    cfg_q.mode  <= mode_t'(cfg_data[1:0]);
				REG_ORIGIN_X:      cfg_q.ox    <= cfg_data[GEOM_W-1:0];
				REG_ORIGIN_Y:      cfg_q.oy    <= cfg_data[GEOM_W-1:0];
				REG_EXTENT_W:      cfg_q.w     <= cfg_data[GEOM_W-1:0];
				REG_EXTENT_H:      cfg_q.h     <= cfg_data[GEOM_W-1:0];
				REG_CORNER_RADIUS: cfg_q.cr    <= cfg_data[GEOM_W-1:0];
				REG_FILL_COLOR:    cfg_q.color <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/sfpc_offset.sv
// First pipeline stage: pixel offsets from the shape origin, bounds tests,
// word address, swapped color and the clamped corner radius. Uses sfpc_pkg.
module sfpc_offset (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         in_valid,
	input  logic [sfpc_pkg::COORD_W-1:0] pixel_x,
	input  logic [sfpc_pkg::COORD_W-1:0] pixel_y,
	input  sfpc_pkg::cfg_t               cfg,
	output logic                         valid_s1,
	output sfpc_pkg::s1_t                data_s1
);
	import sfpc_pkg::*;

	s1_t               nxt;
	logic [OFS_W-1:0]  xe, ye, i, j, w, h, ai_f, aj_f;
	logic [GEOM_W-1:0] wh, hh, m;
	logic              w_pos, h_pos, cr_pos;

	always_comb begin
		xe = {{(OFS_W-COORD_W){1'b0}}, pixel_x};
		ye = {{(OFS_W-COORD_W){1'b0}}, pixel_y};
		i = xe - sext_ofs(cfg.ox);
		j = ye - sext_ofs(cfg.oy);
		w = sext_ofs(cfg.w);
		h = sext_ofs(cfg.h);
		w_pos = !cfg.w[GEOM_W-1] && (cfg.w != '0);
		h_pos = !cfg.h[GEOM_W-1] && (cfg.h != '0);
		cr_pos = !cfg.cr[GEOM_W-1] && (cfg.cr != '0);
		ai_f = i[OFS_W-1] ? -i : i;
		aj_f = j[OFS_W-1] ? -j : j;
		wh = cfg.w >> 1;
		hh = cfg.h >> 1;
		m = cfg.cr;
		if (wh < m) begin
			m = wh;
		end
		if (hh < m) begin
			m = hh;
		end

		nxt.onscreen = (32'(pixel_x) < SCREEN_WIDTH) && (32'(pixel_y) < SCREEN_HEIGHT);
		nxt.mode = cfg.mode;
		nxt.addr = ADDR_W'(32'(pixel_y) * 32'(SCREEN_WIDTH) + 32'(pixel_x));
		nxt.word = {cfg.color[7:0], cfg.color[15:8]};
		nxt.in_rect = !i[OFS_W-1] && ($signed(i) < $signed(w)) &&
			!j[OFS_W-1] && ($signed(j) < $signed(h));
		nxt.ell_ok = w_pos && h_pos &&
			($signed(i) >= -$signed(w)) && ($signed(i) <= $signed(w)) &&
			($signed(j) >= -$signed(h)) && ($signed(j) <= $signed(h));
		nxt.ai = ai_f[MAG_W-1:0];
		nxt.aj = aj_f[MAG_W-1:0];
		nxt.i = i;
		nxt.j = j;
		nxt.reff = (cr_pos && w_pos && h_pos) ? m[RAD_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s1 <= nxt;
		end
	end

endmodule

// File: rtl/core/sfpc_square.sv
// Second and third pipeline stages: squares of offsets and radii and the corner
// distances, then the ellipse cross products and corner squares. Uses sfpc_pkg.
module sfpc_square (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          valid_s1,
	input  sfpc_pkg::s1_t data_s1,
	input  sfpc_pkg::cfg_t cfg,
	output logic          valid_s3,
	output sfpc_pkg::s3_t data_s3
);
	import sfpc_pkg::*;

	logic             valid_s2;
	s2_t              data_s2;
	s2_t              nxt2;
	s3_t              nxt3;
	logic [MAG_W-1:0] rx, ry;
	logic [OFS_W:0]   ie, je, we, he, re, dxf, dyf;
	logic             xlo, xhi, ylo, yhi;

	always_comb begin
		rx = cfg.w[MAG_W-1:0];
		ry = cfg.h[MAG_W-1:0];
		ie = {data_s1.i[OFS_W-1], data_s1.i};
		je = {data_s1.j[OFS_W-1], data_s1.j};
		we = {{(OFS_W+1-GEOM_W){cfg.w[GEOM_W-1]}}, cfg.w};
		he = {{(OFS_W+1-GEOM_W){cfg.h[GEOM_W-1]}}, cfg.h};
		re = {{(OFS_W+1-RAD_W){1'b0}}, data_s1.reff};
		xlo = $signed(ie) < $signed(re);
		xhi = $signed(ie) >= $signed(we - re);
		ylo = $signed(je) < $signed(re);
		yhi = $signed(je) >= $signed(he - re);
		dxf = xlo ? (re - ie - (OFS_W+1)'(1)) : (ie - we + re);
		dyf = ylo ? (re - je - (OFS_W+1)'(1)) : (je - he + re);

		nxt2.onscreen = data_s1.onscreen;
		nxt2.mode = data_s1.mode;
		nxt2.addr = data_s1.addr;
		nxt2.word = data_s1.word;
		nxt2.in_rect = data_s1.in_rect;
		nxt2.ell_ok = data_s1.ell_ok;
		nxt2.ai2 = MAG2_W'(data_s1.ai) * MAG2_W'(data_s1.ai);
		nxt2.aj2 = MAG2_W'(data_s1.aj) * MAG2_W'(data_s1.aj);
		nxt2.rx2 = MAG2_W'(rx) * MAG2_W'(rx);
		nxt2.ry2 = MAG2_W'(ry) * MAG2_W'(ry);
		nxt2.corner = (xlo || xhi) && (ylo || yhi);
		nxt2.dx = dxf[RAD_W-1:0];
		nxt2.dy = dyf[RAD_W-1:0];
		nxt2.reff = data_s1.reff;
	end

	always_comb begin
		nxt3.onscreen = data_s2.onscreen;
		nxt3.mode = data_s2.mode;
		nxt3.addr = data_s2.addr;
		nxt3.word = data_s2.word;
		nxt3.in_rect = data_s2.in_rect;
		nxt3.ell_ok = data_s2.ell_ok;
		nxt3.ell_a = PROD_W'(data_s2.ai2) * PROD_W'(data_s2.ry2);
		nxt3.ell_b = PROD_W'(data_s2.aj2) * PROD_W'(data_s2.rx2);
		nxt3.ell_r = PROD_W'(data_s2.rx2) * PROD_W'(data_s2.ry2);
		nxt3.corner = data_s2.corner;
		nxt3.dx2 = RAD2_W'(data_s2.dx) * RAD2_W'(data_s2.dx);
		nxt3.dy2 = RAD2_W'(data_s2.dy) * RAD2_W'(data_s2.dy);
		nxt3.r2 = RAD2_W'(data_s2.reff) * RAD2_W'(data_s2.reff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= nxt2;
			data_s3 <= nxt3;
		end
	end

endmodule

// File: rtl/core/sfpc_decide.sv
// Last pipeline stage: final compares, shape selection and the output register.
// Uses sfpc_pkg for the stage type and the mode codes.
module sfpc_decide (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          valid_s3,
	input  sfpc_pkg::s3_t                 data_s3,
	output logic                          out_valid,
	output logic                          write_enable,
	output logic [sfpc_pkg::ADDR_W-1:0]   pixel_address,
	output logic [sfpc_pkg::COLOR_W-1:0]  pixel_word
);
	import sfpc_pkg::*;

	logic [PROD_W:0] ell_sum;
	logic [RAD2_W:0] rnd_sum;
	logic            ell_hit, rnd_hit, hit;

	always_comb begin
		ell_sum = {1'b0, data_s3.ell_a} + {1'b0, data_s3.ell_b};
		rnd_sum = {1'b0, data_s3.dx2} + {1'b0, data_s3.dy2};
		ell_hit = data_s3.ell_ok && (ell_sum <= {1'b0, data_s3.ell_r});
		rnd_hit = data_s3.in_rect && !(data_s3.corner && (rnd_sum > {1'b0, data_s3.r2}));
		case (data_s3.mode)
			MODE_CLEAR:   hit = 1'b1;
			MODE_RECT:    hit = data_s3.in_rect;
			MODE_ELLIPSE: hit = ell_hit;
			MODE_ROUNDED: hit = rnd_hit;
			default:      hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			write_enable <= data_s3.onscreen && hit;
			pixel_address <= data_s3.addr;
			pixel_word <= data_s3.word;
		end
	end

endmodule

// File: rtl/core/shape_fill_pixel_coverage.sv
// Top level of the shape fill pixel coverage block; instantiates the register
// file and the four pipeline stages, and depends on sfpc_pkg.
// The block takes one pixel coordinate per clock unless in_stall is high and
// presents one result per pixel, in order, on the output. The four-stage
// pipeline holds offsets and bounds, then squares, then the ellipse cross
// products, then the final compares in the output register. A stall on the
// output freezes the whole pipeline and is passed straight back as in_stall.
// Configuration writes are always taken and act from the next cycle; they are
// meant for times when no pixel is in flight.
module shape_fill_pixel_coverage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfpc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sfpc_pkg::COORD_W-1:0]    pixel_x,
	input  logic [sfpc_pkg::COORD_W-1:0]    pixel_y,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           write_enable,
	output logic [sfpc_pkg::ADDR_W-1:0]     pixel_address,
	output logic [sfpc_pkg::COLOR_W-1:0]    pixel_word
);
	import sfpc_pkg::*;

	cfg_t cfg;
	s1_t  data_s1;
	s3_t  data_s3;
	logic valid_s1, valid_s3, advance;

	assign advance = !(out_valid && out_stall);
	assign in_stall = !advance;

	sfpc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfpc_offset u_offset (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (in_valid),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	sfpc_square u_square (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.cfg      (cfg),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	sfpc_decide u_decide (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.valid_s3      (valid_s3),
		.data_s3       (data_s3),
		.out_valid     (out_valid),
		.write_enable  (write_enable),
		.pixel_address (pixel_address),
		.pixel_word    (pixel_word)
	);

endmodule

// File: rtl/core/sfpc_checker.sv
// Port-level checker for the shape fill pixel coverage block, bound to the top.
// Depends on shape_fill_pixel_coverage_assert.svh for the assertion macros.
`include "shape_fill_pixel_coverage_assert.svh"

module sfpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        write_enable,
	input logic [13:0] pixel_address,
	input logic [15:0] pixel_word
);

	// The input side stalls exactly when a finished result is held back.
	`SFPC_ASSERT_IMPLY(a_stall_tracks_output, clk, arst_n, in_valid || !in_valid, in_stall == (out_valid && out_stall))
	`SFPC_ASSERT_NEXT(a_stalled_result_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(write_enable) && $stable(pixel_address) && $stable(pixel_word))
	`SFPC_ASSERT_IMPLY(a_cfg_never_refused, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind shape_fill_pixel_coverage sfpc_checker u_sfpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.write_enable  (write_enable),
	.pixel_address (pixel_address),
	.pixel_word    (pixel_word)
);
